@@ design/cbc_pkg.sv @@
// cbc_pkg: shared constants, register indexes and types of the colour blob centroid unit
// no dependencies; imported by the interfaces and every module of the block
package cbc_pkg;

    // frame geometry limits
    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // field and accumulator widths
    localparam int CH_W      = 8;
    localparam int WIDTH_W   = 12;
    localparam int SEL_W     = 2;
    localparam int SUM_W     = 33;
    localparam int CNT_W     = 23;
    localparam int CENTRE_W  = 11;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LEVEL  = 2'd3;

    // register reset values
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST    = 12'd640;
    localparam logic [SEL_W-1:0]   CHANNEL_SELECT_RST = 2'd1;
    localparam logic [CH_W-1:0]    WHITE_LEVEL_RST    = 8'd220;
    localparam logic [CH_W-1:0]    CHANNEL_LEVEL_RST  = 8'd230;

    // channel selector codes
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_RED   = 2'd2;

    // divider and frame queue sizing
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // live configuration
    typedef struct packed {
        logic [WIDTH_W-1:0] image_width;
        logic [SEL_W-1:0]   channel_select;
        logic [CH_W-1:0]    white_level;
        logic [CH_W-1:0]    channel_level;
    } cbc_cfg_t;

    // per-frame totals handed from the accumulator to the divider
    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        logic [CNT_W-1:0] count;
    } cbc_sums_t;

    // frame queue status seen by the divider side
    typedef struct packed {
        logic      valid;
        cbc_sums_t head;
    } cbc_qstat_t;

endpackage

@@ design/cbc_ifs.sv @@
// cbc_pixel_if and cbc_centroid_if: valid/ready channels of the colour blob centroid unit
// depends on cbc_pkg for the field widths
interface cbc_pixel_if;
    import cbc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            frame_end;

    modport source (output valid, output blue, output green, output red, output frame_end,
                    input ready);
    modport sink   (input valid, input blue, input green, input red, input frame_end,
                    output ready);
endinterface

interface cbc_centroid_if;
    import cbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CENTRE_W-1:0] center_row;
    logic [CENTRE_W-1:0] center_col;
    logic                no_pixels;

    modport source (output valid, output center_row, output center_col, output no_pixels,
                    input ready);
    modport sink   (input valid, input center_row, input center_col, input no_pixels,
                    output ready);
endinterface

@@ design/cbc_front.sv @@
// cbc_front: pixel classifier, raster position tracking and per-frame accumulation
// depends on cbc_pkg and cbc_pixel_if; pushes frame totals into cbc_queue
module cbc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  cbc_pkg::cbc_cfg_t cfg,
    cbc_pixel_if.sink         pixel,
    input  logic              q_full,
    output logic              push,
    output cbc_pkg::cbc_sums_t push_sums
);
    import cbc_pkg::*;

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SUM_W-1:0]   row_sum_reg;
    logic [SUM_W-1:0]   col_sum_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               accept;
    logic               black;
    logic               sel_ok;
    logic [CH_W-1:0]    sel_val;
    logic [CH_W-1:0]    test_val;
    logic               hit;
    logic [SUM_W:0]     row_add;
    logic [SUM_W:0]     col_add;
    cbc_sums_t          sums_next;
    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] col_plus;

    // stall only when the frame queue has no room
    assign pixel.ready = !q_full;
    assign accept      = pixel.valid && pixel.ready;

    // bright-white pixels are treated as black
    assign black = (pixel.blue >= cfg.white_level) && (pixel.green >= cfg.white_level)
                   && (pixel.red >= cfg.white_level);

    // channel select
    always_comb
    begin
        sel_ok  = 1'b1;
        sel_val = pixel.green;
        unique case (cfg.channel_select)
            SEL_BLUE:  sel_val = pixel.blue;
            SEL_GREEN: sel_val = pixel.green;
            SEL_RED:   sel_val = pixel.red;
            default:   sel_ok  = 1'b0;
        endcase
    end

    assign test_val = black ? '0 : sel_val;
    assign hit      = sel_ok && (test_val >= cfg.channel_level);

    // saturating accumulation including the current pixel
    assign row_add = {1'b0, row_sum_reg} + (SUM_W+1)'(row_reg);
    assign col_add = {1'b0, col_sum_reg} + (SUM_W+1)'(col_reg);

    always_comb
    begin
        sums_next.row_sum = row_sum_reg;
        sums_next.col_sum = col_sum_reg;
        sums_next.count   = count_reg;
        if (hit)
        begin
            sums_next.row_sum = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
            sums_next.col_sum = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
            sums_next.count   = (&count_reg) ? count_reg : count_reg + 1'b1;
        end
    end

    assign push      = accept && pixel.frame_end;
    assign push_sums = sums_next;

    // effective row length
    assign width_eff = (cfg.image_width == '0 || cfg.image_width > WIDTH_W'(MAX_COLS))
                       ? WIDTH_W'(MAX_COLS) : cfg.image_width;
    assign col_plus  = WIDTH_W'(col_reg) + 1'b1;

    // position and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (pixel.frame_end)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                row_sum_reg <= '0;
                col_sum_reg <= '0;
                count_reg   <= '0;
            end
            else
            begin
                row_sum_reg <= sums_next.row_sum;
                col_sum_reg <= sums_next.col_sum;
                count_reg   <= sums_next.count;
                if (col_plus >= width_eff)
                begin
                    col_reg <= '0;
                    if (row_reg != ROW_W'(MAX_ROWS - 1))
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_plus[COL_W-1:0];
                end
            end
        end
    end

endmodule

@@ design/cbc_queue.sv @@
// cbc_queue: short queue of frame totals between accumulator and divider
// depends on cbc_pkg for cbc_sums_t and the queue depth
module cbc_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbc_pkg::cbc_sums_t  push_sums,
    output logic                full,
    input  logic                pop,
    output cbc_pkg::cbc_qstat_t status
);
    import cbc_pkg::*;

    cbc_sums_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full          = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.valid  = (fill_reg != '0);
    assign status.head   = entry_reg[rd_ptr_reg];
    assign do_push       = push && !full;
    assign do_pop        = pop && status.valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_sums;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/cbc_back.sv @@
// cbc_back: iterative divider for the row and column means, plus the result register
// depends on cbc_pkg and cbc_centroid_if; pops frame totals from cbc_queue
module cbc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  cbc_pkg::cbc_qstat_t status,
    output logic                pop,
    cbc_centroid_if.source      centroid
);
    import cbc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    row_q_reg;
    logic [SUM_W-1:0]    col_q_reg;
    logic [CNT_W-1:0]    row_rem_reg;
    logic [CNT_W-1:0]    col_rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic                empty_reg;
    logic                out_valid_reg;
    logic [CENTRE_W-1:0] out_row_reg;
    logic [CENTRE_W-1:0] out_col_reg;
    logic                out_none_reg;

    logic [CNT_W+SUM_W-1:0] row_step;
    logic [CNT_W+SUM_W-1:0] col_step;
    logic [CENTRE_W-1:0]    row_clamp;
    logic [CENTRE_W-1:0]    col_clamp;
    logic                   load_out;
    logic                   take_out;

    // one restoring division step: returns {remainder, shifted quotient}
    function automatic logic [CNT_W+SUM_W-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                       input logic [SUM_W-1:0] q,
                                                       input logic [CNT_W-1:0] den);
        logic [CNT_W:0]   rem_sh;
        logic [CNT_W:0]   diff;
        logic             ge;
        logic [CNT_W-1:0] rem_new;
        rem_sh  = {rem, q[SUM_W-1]};
        diff    = rem_sh - {1'b0, den};
        ge      = (rem_sh >= {1'b0, den});
        rem_new = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        return {rem_new, q[SUM_W-2:0], ge};
    endfunction

    // saturate a quotient to the centre field
    function automatic logic [CENTRE_W-1:0] clamp_centre(input logic [SUM_W-1:0] q);
        return (q[SUM_W-1:CENTRE_W] != '0) ? '1 : q[CENTRE_W-1:0];
    endfunction

    assign row_step  = div_step(row_rem_reg, row_q_reg, den_reg);
    assign col_step  = div_step(col_rem_reg, col_q_reg, den_reg);
    assign row_clamp = clamp_centre(row_q_reg);
    assign col_clamp = clamp_centre(col_q_reg);

    assign pop      = (state_reg == S_IDLE) && status.valid;
    assign take_out = out_valid_reg && centroid.ready;
    assign load_out = (state_reg == S_WAIT) && (!out_valid_reg || centroid.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.valid)
                begin
                    state_next = (status.head.count == '0) ? S_WAIT : S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (take_out)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            empty_reg   <= (status.head.count == '0);
            den_reg     <= status.head.count;
            row_q_reg   <= (status.head.count == '0) ? '0 : status.head.row_sum;
            col_q_reg   <= (status.head.count == '0) ? '0 : status.head.col_sum;
            row_rem_reg <= '0;
            col_rem_reg <= '0;
            step_reg    <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            {row_rem_reg, row_q_reg} <= row_step;
            {col_rem_reg, col_q_reg} <= col_step;
            step_reg                 <= step_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg  <= empty_reg ? '0 : row_clamp;
            out_col_reg  <= empty_reg ? '0 : col_clamp;
            out_none_reg <= empty_reg;
        end
    end

    assign centroid.valid      = out_valid_reg;
    assign centroid.center_row = out_row_reg;
    assign centroid.center_col = out_col_reg;
    assign centroid.no_pixels  = out_none_reg;

`ifndef SYNTHESIS
    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("divider running with a zero divisor");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> step_reg < STEP_W'(DIV_STEPS))
        else $error("divider step count overran");

    a_empty_centre_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_none_reg |-> out_row_reg == '0 && out_col_reg == '0)
        else $error("empty frame reported a non-zero centre");

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && step_reg == STEP_W'(DIV_STEPS - 1) |=> state_reg == S_WAIT)
        else $error("divider did not finish after its last step");
`endif

endmodule

@@ design/color_blob_centroid_unit.sv @@
// color_blob_centroid_unit: top level of the colour blob centroid unit
// depends on cbc_pkg, cbc_ifs, cbc_front, cbc_queue and cbc_back
//
// Pixels of a raster frame stream in on the pixel channel, one per clock, with frame_end on
// the last pixel. Each pixel is classified and accumulated as it arrives, so the pixel input
// is ready every cycle as long as the two-entry frame queue has room. At each frame end the
// row sum, column sum and match count go into that queue; a shared bit-serial divider takes
// one frame at a time: it loads the frame, works out the 33 quotient bits for row and column
// in parallel and hands the result to the result register; a frame with no matching pixel
// skips the division. The pixel input therefore stalls only when short frames follow each
// other faster than the divider can finish them or results are not taken. Configuration
// registers take effect at once and should be written between frames.
module color_blob_centroid_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    cbc_pixel_if.sink                       pixel,
    cbc_centroid_if.source                  centroid
);
    import cbc_pkg::*;

    cbc_cfg_t   cfg_reg;
    logic       q_full;
    logic       push;
    cbc_sums_t  push_sums;
    logic       pop;
    cbc_qstat_t q_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= IMAGE_WIDTH_RST;
            cfg_reg.channel_select <= CHANNEL_SELECT_RST;
            cfg_reg.white_level    <= WHITE_LEVEL_RST;
            cfg_reg.channel_level  <= CHANNEL_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[WIDTH_W-1:0];
                REG_CHANNEL_SELECT: cfg_reg.channel_select <= cfg_data[SEL_W-1:0];
                REG_WHITE_LEVEL:    cfg_reg.white_level    <= cfg_data[CH_W-1:0];
                REG_CHANNEL_LEVEL:  cfg_reg.channel_level  <= cfg_data[CH_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // accumulator side
    cbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pixel     (pixel),
        .q_full    (q_full),
        .push      (push),
        .push_sums (push_sums)
    );

    // frame totals queue
    cbc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sums (push_sums),
        .full      (q_full),
        .pop       (pop),
        .status    (q_status)
    );

    // divider side
    cbc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (q_status),
        .pop      (pop),
        .centroid (centroid)
    );

endmodule
